FILE: rtl/nfcs_pkg.sv
// Package with the types, codes and constants of the NOR flash command sequencer.
`timescale 1ns / 1ps
package nfcs_pkg;

	// Flash geometry.
	localparam int FLASH_BYTES   = 4194304;
	localparam int SECTOR_COUNT  = 71;
	localparam int SMALL_SECTORS = 8;
	localparam int SMALL_BYTES   = SMALL_SECTORS * 8192;
	localparam int EOFF_W        = 24;

	// Command codes of an input word.
	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_PROG  = 3'd1;
	localparam logic [2:0] CMD_ERASE = 3'd2;
	localparam logic [2:0] CMD_RESET = 3'd3;
	localparam logic [2:0] CMD_POLL  = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Completion status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_RANGE      = 2'd1;
	localparam logic [1:0] ST_ERASE_FAIL = 2'd2;
	localparam logic [1:0] ST_PROG_FAIL  = 2'd3;

	// Flash command bytes and unlock offsets.
	localparam logic [7:0]  FL_UNLOCK1    = 8'haa;
	localparam logic [7:0]  FL_UNLOCK2    = 8'h55;
	localparam logic [7:0]  FL_ERASE_SET  = 8'h80;
	localparam logic [7:0]  FL_PROG_SET   = 8'ha0;
	localparam logic [7:0]  FL_SECT_ERASE = 8'h30;
	localparam logic [7:0]  FL_RESET      = 8'hf0;
	localparam logic [7:0]  DQ7_MASK      = 8'h80;
	localparam logic [7:0]  DQ5_MASK      = 8'h20;
	localparam logic [7:0]  TOGGLE_MASK   = 8'h44;
	localparam logic [31:0] ADDR_555      = 32'h00000555;
	localparam logic [31:0] ADDR_AAA      = 32'h00000aaa;

	// One input word.
	typedef struct packed {
		logic [2:0]  command;
		logic [22:0] offset;
		logic [7:0]  write_data;
		logic [6:0]  sector;
		logic [7:0]  bus_read_value;
	} cmd_word_t;

	// One result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] bus_address;
		logic [7:0]  bus_data;
		logic [1:0]  status;
		logic [7:0]  read_data;
		logic        last;
	} result_word_t;

	// Kinds of result bursts that one input word can cause.
	typedef enum logic [2:0] {
		BT_NONE  = 3'd0,
		BT_RESET = 3'd1,
		BT_READ  = 3'd2,
		BT_PROG  = 3'd3,
		BT_ERASE = 3'd4,
		BT_DONE  = 3'd5,
		BT_FAIL  = 3'd6
	} burst_type_t;

	// Description of one burst handed from the controller to the emitter.
	typedef struct packed {
		burst_type_t btype;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [1:0]  status;
		logic [7:0]  rdata;
	} burst_t;

	// Number of result words in a burst.
	function automatic logic [2:0] burst_len(input burst_type_t bt);
		logic [2:0] n;
		n = 3'd0;
		case (bt)
			BT_RESET: n = 3'd2;
			BT_READ:  n = 3'd1;
			BT_PROG:  n = 3'd5;
			BT_ERASE: n = 3'd7;
			BT_DONE:  n = 3'd1;
			BT_FAIL:  n = 3'd2;
			default:  n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer: ports, base register, input register.
//
//   Channel  Direction  Handshake             Word
//   cfg      in         cfg_valid/cfg_ready   cfg_data: base address of the flash
//   in       in         in_valid/in_ready     in_word: one request or poll reply
//   out      out        out_valid/out_ready   out_word: bus write, bus read or done
//
// An accepted word is decoded in the input register and leaves it once the emitter
// can take its burst; its result words pass through the burst register and the
// output register. The emitter issues one result word per cycle while the output
// is not stalled, up to seven result words for an erase. Reset clears the operation
// state and the base address. A stalled output holds the emitter, then the input register.
`timescale 1ns / 1ps
module nor_flash_command_sequencer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  nfcs_pkg::cmd_word_t    in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output nfcs_pkg::result_word_t out_word
);
	import nfcs_pkg::*;

	logic [31:0] base_q;
	logic        valid_s1;
	cmd_word_t   item_s1;
	logic        consume, burst_load, burst_free;
	burst_t      burst;

	// Base address register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'h0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// Input register.
	assign in_ready = !valid_s1 || consume;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_word;
		end
	end

	nfcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.item         (item_s1),
		.base_address (base_q),
		.burst_free   (burst_free),
		.consume      (consume),
		.burst_load   (burst_load),
		.burst        (burst)
	);

	nfcs_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_q),
		.burst_load   (burst_load),
		.burst        (burst),
		.burst_free   (burst_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_word     (out_word)
	);

endmodule

FILE: rtl/nfcs_ctrl.sv
// Operation state and decode of one input word into a burst of bus cycles.
`timescale 1ns / 1ps
module nfcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  nfcs_pkg::cmd_word_t item,
	input  logic [31:0]        base_address,
	input  logic               burst_free,
	output logic               consume,
	output logic               burst_load,
	output nfcs_pkg::burst_t   burst
);
	import nfcs_pkg::*;

	typedef enum logic [7:0] {
		PH_IDLE        = 8'b0000_0001,
		PH_READ        = 8'b0000_0010,
		PH_PROG        = 8'b0000_0100,
		PH_PROG_RE     = 8'b0000_1000,
		PH_ERASE_FIRST = 8'b0001_0000,
		PH_ERASE       = 8'b0010_0000,
		PH_ERASE_RE1   = 8'b0100_0000,
		PH_ERASE_RE2   = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  prev_q, prev_d;
	logic [31:0] target_q, target_d;
	logic [7:0]  tdata_q, tdata_d;
	logic [6:0]  sec_rel;
	logic [EOFF_W-1:0] eoff_small, eoff_large, eoff;
	logic        bad_sector, out_range;
	logic [31:0] new_target;
	logic [7:0]  rv;
	logic        dq7_match, toggle_same, dq5_set;
	burst_t      b;

	// Byte offset of the request, from the offset or the sector number.
	always_comb begin
		sec_rel    = item.sector - 7'(SMALL_SECTORS);
		eoff_small = EOFF_W'({item.sector, 13'h0});
		eoff_large = EOFF_W'(SMALL_BYTES) + EOFF_W'({sec_rel, 16'h0});
		if (item.command == CMD_ERASE) begin
			eoff = (item.sector < 7'(SMALL_SECTORS)) ? eoff_small : eoff_large;
		end else begin
			eoff = EOFF_W'(item.offset);
		end
		bad_sector  = (item.command == CMD_ERASE) && (item.sector >= 7'(SECTOR_COUNT));
		out_range   = bad_sector || (eoff >= EOFF_W'(FLASH_BYTES));
		new_target  = base_address + 32'(eoff);
		rv          = item.bus_read_value;
		dq7_match   = ((rv ^ tdata_q) & DQ7_MASK) == 8'h00;
		toggle_same = ((rv ^ prev_q) & TOGGLE_MASK) == 8'h00;
		dq5_set     = (rv & DQ5_MASK) != 8'h00;
	end

	// Next state and burst for the word at the head of the input register.
	always_comb begin
		phase_d  = phase_q;
		prev_d   = prev_q;
		target_d = target_q;
		tdata_d  = tdata_q;
		b.btype  = BT_NONE;
		b.addr   = target_q;
		b.data   = item.write_data;
		b.status = ST_OK;
		b.rdata  = 8'h00;
		case (item.command)
			CMD_RESET: begin
				phase_d = PH_IDLE;
				b.btype = BT_RESET;
			end
			CMD_READ, CMD_PROG, CMD_ERASE: begin
				if (phase_q == PH_IDLE) begin
					if (out_range) begin
						b.btype  = BT_DONE;
						b.addr   = 32'h0;
						b.status = ST_RANGE;
					end else begin
						target_d = new_target;
						b.addr   = new_target;
						if (item.command == CMD_READ) begin
							phase_d = PH_READ;
							b.btype = BT_READ;
						end else if (item.command == CMD_PROG) begin
							phase_d = PH_PROG;
							tdata_d = item.write_data;
							b.btype = BT_PROG;
						end else begin
							phase_d = PH_ERASE_FIRST;
							b.btype = BT_ERASE;
						end
					end
				end
			end
			CMD_POLL: begin
				unique case (phase_q)
					PH_IDLE: begin
						b.btype = BT_NONE;
					end
					PH_READ: begin
						phase_d = PH_IDLE;
						b.btype = BT_DONE;
						b.rdata = rv;
					end
					PH_PROG: begin
						if (dq7_match) begin
							phase_d = PH_IDLE;
							b.btype = BT_DONE;
						end else begin
							if (dq5_set) begin
								phase_d = PH_PROG_RE;
							end
							b.btype = BT_READ;
						end
					end
					PH_PROG_RE: begin
						phase_d = PH_IDLE;
						if (dq7_match) begin
							b.btype = BT_DONE;
						end else begin
							b.btype  = BT_FAIL;
							b.status = ST_PROG_FAIL;
						end
					end
					PH_ERASE_FIRST: begin
						prev_d  = rv;
						phase_d = PH_ERASE;
						b.btype = BT_READ;
					end
					PH_ERASE: begin
						if (toggle_same) begin
							phase_d = PH_IDLE;
							b.btype = BT_DONE;
						end else begin
							if (dq5_set) begin
								phase_d = PH_ERASE_RE1;
							end else begin
								prev_d = rv;
							end
							b.btype = BT_READ;
						end
					end
					PH_ERASE_RE1: begin
						prev_d  = rv;
						phase_d = PH_ERASE_RE2;
						b.btype = BT_READ;
					end
					PH_ERASE_RE2: begin
						phase_d = PH_IDLE;
						if (toggle_same) begin
							b.btype = BT_DONE;
						end else begin
							b.btype  = BT_FAIL;
							b.status = ST_ERASE_FAIL;
						end
					end
					default: begin
						b.btype = BT_NONE;
					end
				endcase
			end
			default: begin
				b.btype = BT_NONE;
			end
		endcase
	end

	// A word leaves the input register once the emitter can take its burst.
	assign consume    = item_valid && burst_free;
	assign burst_load = consume && (b.btype != BT_NONE);
	assign burst      = b;

	// Operation state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			prev_q   <= 8'h00;
			target_q <= 32'h0;
			tdata_q  <= 8'h00;
		end else if (consume) begin
			phase_q  <= phase_d;
			prev_q   <= prev_d;
			target_q <= target_d;
			tdata_q  <= tdata_d;
		end
	end

endmodule

FILE: rtl/nfcs_emit.sv
// Burst register and output register that issue one result word per cycle while the output is not stalled.
`timescale 1ns / 1ps
module nfcs_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            base_address,
	input  logic                   burst_load,
	input  nfcs_pkg::burst_t       burst,
	output logic                   burst_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output nfcs_pkg::result_word_t out_word
);
	import nfcs_pkg::*;

	burst_t       burst_q;
	logic         burst_valid_q;
	logic [2:0]   idx_q;
	logic         out_valid_q;
	result_word_t out_q;
	result_word_t elem;
	logic         fire, is_last;
	logic [31:0]  a555, aaaa;

	// Result word at the current position of the burst.
	always_comb begin
		a555 = base_address + ADDR_555;
		aaaa = base_address + ADDR_AAA;
		elem.kind        = KIND_WRITE;
		elem.bus_address = burst_q.addr;
		elem.bus_data    = 8'h00;
		elem.status      = ST_OK;
		elem.read_data   = 8'h00;
		case (burst_q.btype)
			BT_RESET: begin
				if (idx_q == 3'd0) begin
					elem.bus_address = base_address;
					elem.bus_data    = FL_RESET;
				end else begin
					elem.kind        = KIND_DONE;
					elem.bus_address = 32'h0;
				end
			end
			BT_PROG: begin
				case (idx_q)
					3'd0: begin
						elem.bus_address = aaaa;
						elem.bus_data    = FL_UNLOCK1;
					end
					3'd1: begin
						elem.bus_address = a555;
						elem.bus_data    = FL_UNLOCK2;
					end
					3'd2: begin
						elem.bus_address = aaaa;
						elem.bus_data    = FL_PROG_SET;
					end
					3'd3: begin
						elem.bus_data = burst_q.data;
					end
					default: begin
						elem.kind = KIND_READ;
					end
				endcase
			end
			BT_ERASE: begin
				case (idx_q)
					3'd0, 3'd3: begin
						elem.bus_address = aaaa;
						elem.bus_data    = FL_UNLOCK1;
					end
					3'd1, 3'd4: begin
						elem.bus_address = a555;
						elem.bus_data    = FL_UNLOCK2;
					end
					3'd2: begin
						elem.bus_address = aaaa;
						elem.bus_data    = FL_ERASE_SET;
					end
					3'd5: begin
						elem.bus_data = FL_SECT_ERASE;
					end
					default: begin
						elem.kind = KIND_READ;
					end
				endcase
			end
			BT_DONE: begin
				elem.kind      = KIND_DONE;
				elem.status    = burst_q.status;
				elem.read_data = burst_q.rdata;
			end
			BT_FAIL: begin
				if (idx_q == 3'd0) begin
					elem.bus_data = FL_RESET;
				end else begin
					elem.kind   = KIND_DONE;
					elem.status = burst_q.status;
				end
			end
			default: begin
				elem.kind = KIND_READ;
			end
		endcase
		is_last   = idx_q == (burst_len(burst_q.btype) - 3'd1);
		elem.last = is_last;
	end

	// A word moves into the output register when it is empty or being taken.
	assign fire       = burst_valid_q && (!out_valid_q || out_ready);
	assign burst_free = !burst_valid_q || (fire && is_last);

	// Burst position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			idx_q         <= 3'd0;
		end else if (burst_load) begin
			burst_valid_q <= 1'b1;
			idx_q         <= 3'd0;
		end else if (fire) begin
			if (is_last) begin
				burst_valid_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	// Burst payload.
	always_ff @(posedge clk) begin
		if (burst_load) begin
			burst_q <= burst;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= elem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

FILE: bench/nor_flash_command_sequencer_test.sv
// Self-checking testbench of the NOR flash command sequencer with a built-in predictor.
`timescale 1ns / 1ps
module nor_flash_command_sequencer_test;
	import nfcs_pkg::*;

	// Command codes that the block ignores.
	localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
	localparam int         QUIET_LIMIT   = 4000;
	localparam int         HOLD_CYCLES   = 12;
	localparam int         DRILL_ROWS    = 26;
	localparam result_word_t NO_WORD     = '0;

	// Operation phases as the predictor tracks them.
	typedef enum logic [2:0] {
		SQ_IDLE, SQ_READ, SQ_PROG, SQ_PROG_RETRY,
		SQ_ERASE_FIRST, SQ_ERASE, SQ_ERASE_RETRY1, SQ_ERASE_RETRY2
	} seq_phase_t;

	// One directed word, with its results typed in where they are obvious.
	typedef struct packed {
		cmd_word_t    word;
		logic         typed;
		logic [1:0]   typed_count;
		result_word_t first_word;
		result_word_t second_word;
	} drill_row_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data  = '0;
	logic         in_valid  = 1'b0;
	logic         in_ready;
	cmd_word_t    in_word   = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	result_word_t out_word;

	// Predictor state.
	logic [31:0]  flash_base    = '0;
	seq_phase_t   seq_state     = SQ_IDLE;
	logic [7:0]   last_sample   = '0;
	logic [31:0]  target_addr   = '0;
	logic [7:0]   target_byte   = '0;
	result_word_t cycle_list[$];
	result_word_t bus_expect[$];

	int           mismatches    = 0;
	int           result_items  = 0;
	int           words_seen    = 0;
	int           burst_left    = 0;
	int           quiet_cycles  = 0;
	int           stall_span    = 0;
	int           stall_mode    = 0;
	result_word_t want_word;

	nor_flash_command_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// Free-running clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string msg);
		if (mismatches < 100) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want_v);
		if (got !== want_v) begin
			report_mismatch($sformatf("word %0d %s: got %h, expected %h",
				words_seen, name, got, want_v));
		end
	endtask

	function automatic result_word_t bus_word(input logic [1:0] kind,
			input logic [31:0] addr, input logic [7:0] data, input logic [1:0] st,
			input logic [7:0] rd, input logic last);
		result_word_t r;
		r.kind        = kind;
		r.bus_address = addr;
		r.bus_data    = data;
		r.status      = st;
		r.read_data   = rd;
		r.last        = last;
		return r;
	endfunction

	function automatic void add_cycle(input logic [1:0] kind, input logic [31:0] addr,
			input logic [7:0] data, input logic [1:0] st, input logic [7:0] rd);
		cycle_list.push_back(bus_word(kind, addr, data, st, rd, 1'b0));
	endfunction

	// Works out the result words of one accepted input word into cycle_list.
	task automatic sequence_bus_cycles(input cmd_word_t w);
		logic [31:0] eoff;
		logic [31:0] a555;
		logic [31:0] aaaa;
		logic [7:0]  rv;
		logic        in_range;
		cycle_list.delete();
		a555     = flash_base + ADDR_555;
		aaaa     = flash_base + ADDR_AAA;
		rv       = w.bus_read_value;
		in_range = 1'b1;
		eoff     = '0;
		case (w.command)
			CMD_RESET: begin
				seq_state = SQ_IDLE;
				add_cycle(KIND_WRITE, flash_base, FL_RESET, ST_OK, 8'h00);
				add_cycle(KIND_DONE, 32'h0, 8'h00, ST_OK, 8'h00);
			end
			CMD_READ, CMD_PROG, CMD_ERASE: begin
				// New requests are only taken while no operation is running.
				if (seq_state == SQ_IDLE) begin
					if (w.command == CMD_ERASE) begin
						if (w.sector >= SECTOR_COUNT) begin
							in_range = 1'b0;
						end else if (w.sector < SMALL_SECTORS) begin
							eoff = 32'(w.sector) << 13;
						end else begin
							eoff = SMALL_BYTES + ((32'(w.sector) - SMALL_SECTORS) << 16);
						end
					end else begin
						eoff = 32'(w.offset);
					end
					if (in_range && eoff >= FLASH_BYTES) begin
						in_range = 1'b0;
					end
					if (!in_range) begin
						add_cycle(KIND_DONE, 32'h0, 8'h00, ST_RANGE, 8'h00);
					end else begin
						target_addr = flash_base + eoff;
						case (w.command)
							CMD_READ: begin
								seq_state = SQ_READ;
								add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
							end
							CMD_PROG: begin
								target_byte = w.write_data;
								seq_state   = SQ_PROG;
								add_cycle(KIND_WRITE, aaaa, FL_UNLOCK1, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, a555, FL_UNLOCK2, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, aaaa, FL_PROG_SET, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, target_addr, w.write_data, ST_OK, 8'h00);
								add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
							end
							default: begin
								seq_state = SQ_ERASE_FIRST;
								add_cycle(KIND_WRITE, aaaa, FL_UNLOCK1, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, a555, FL_UNLOCK2, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, aaaa, FL_ERASE_SET, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, aaaa, FL_UNLOCK1, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, a555, FL_UNLOCK2, ST_OK, 8'h00);
								add_cycle(KIND_WRITE, target_addr, FL_SECT_ERASE, ST_OK, 8'h00);
								add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
							end
						endcase
					end
				end
			end
			CMD_POLL: begin
				case (seq_state)
					SQ_READ: begin
						seq_state = SQ_IDLE;
						add_cycle(KIND_DONE, target_addr, 8'h00, ST_OK, rv);
					end
					SQ_PROG: begin
						// DQ7 equal to the data bit means the program has finished.
						if (((rv ^ target_byte) & DQ7_MASK) == 0) begin
							seq_state = SQ_IDLE;
							add_cycle(KIND_DONE, target_addr, 8'h00, ST_OK, 8'h00);
						end else begin
							if ((rv & DQ5_MASK) != 0) begin
								seq_state = SQ_PROG_RETRY;
							end
							add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
						end
					end
					SQ_PROG_RETRY: begin
						seq_state = SQ_IDLE;
						if (((rv ^ target_byte) & DQ7_MASK) == 0) begin
							add_cycle(KIND_DONE, target_addr, 8'h00, ST_OK, 8'h00);
						end else begin
							add_cycle(KIND_WRITE, target_addr, FL_RESET, ST_OK, 8'h00);
							add_cycle(KIND_DONE, target_addr, 8'h00, ST_PROG_FAIL, 8'h00);
						end
					end
					SQ_ERASE_FIRST: begin
						last_sample = rv;
						seq_state   = SQ_ERASE;
						add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
					end
					SQ_ERASE: begin
						// Toggle bits that stop toggling mean the erase has finished.
						if (((rv ^ last_sample) & TOGGLE_MASK) == 0) begin
							seq_state = SQ_IDLE;
							add_cycle(KIND_DONE, target_addr, 8'h00, ST_OK, 8'h00);
						end else begin
							if ((rv & DQ5_MASK) != 0) begin
								seq_state = SQ_ERASE_RETRY1;
							end else begin
								last_sample = rv;
							end
							add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
						end
					end
					SQ_ERASE_RETRY1: begin
						last_sample = rv;
						seq_state   = SQ_ERASE_RETRY2;
						add_cycle(KIND_READ, target_addr, 8'h00, ST_OK, 8'h00);
					end
					SQ_ERASE_RETRY2: begin
						seq_state = SQ_IDLE;
						if (((rv ^ last_sample) & TOGGLE_MASK) == 0) begin
							add_cycle(KIND_DONE, target_addr, 8'h00, ST_OK, 8'h00);
						end else begin
							add_cycle(KIND_WRITE, target_addr, FL_RESET, ST_OK, 8'h00);
							add_cycle(KIND_DONE, target_addr, 8'h00, ST_ERASE_FAIL, 8'h00);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (cycle_list.size() > 0) begin
			cycle_list[cycle_list.size() - 1].last = 1'b1;
		end
	endtask

	// Offers one input word in bursts with random gaps, and waits for its acceptance.
	task automatic send_word(input cmd_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				if (in_valid) begin
					in_valid <= 1'b0;
				end
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic issue(input cmd_word_t w);
		send_word(w);
		sequence_bus_cycles(w);
		foreach (cycle_list[i]) begin
			bus_expect.push_back(cycle_list[i]);
		end
		if (cycle_list.size() > 0) begin
			result_items++;
		end
	endtask

	// Holds the sender until every expected word has come and the block has settled.
	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		wait (bus_expect.size() == 0);
		@(negedge clk);
		repeat (HOLD_CYCLES) @(negedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		flash_base = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic cmd_word_t random_word(input logic [2:0] command);
		logic [63:0] r;
		cmd_word_t   w;
		r = {$urandom, $urandom};
		w = r[$bits(cmd_word_t) - 1:0];
		w.command = command;
		return w;
	endfunction

	// Flash status byte for the next poll, which ends or continues the operation at random.
	function automatic logic [7:0] poll_reply();
		logic [7:0] r;
		logic [7:0] flip;
		int         pick;
		r    = 8'($urandom);
		pick = $urandom_range(0, 3);
		case ($urandom_range(0, 2))
			0:       flip = 8'h04;
			1:       flip = 8'h40;
			default: flip = TOGGLE_MASK;
		endcase
		case (seq_state)
			SQ_PROG, SQ_PROG_RETRY: begin
				if (pick >= 2) begin
					r[7] = ~target_byte[7];
					r[5] = (pick == 3);
				end else begin
					r[7] = target_byte[7];
				end
			end
			SQ_ERASE, SQ_ERASE_RETRY2: begin
				r = (r & ~TOGGLE_MASK) | (last_sample & TOGGLE_MASK);
				if (pick >= 2) begin
					r    = r ^ flip;
					r[5] = (pick == 3);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Result word checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (bus_expect.size() == 0) begin
				report_mismatch($sformatf("word %0d with nothing expected: kind %0d addr %h",
					words_seen, out_word.kind, out_word.bus_address));
			end else begin
				want_word = bus_expect.pop_front();
				check_field("kind", 32'(out_word.kind), 32'(want_word.kind));
				check_field("bus_address", out_word.bus_address, want_word.bus_address);
				check_field("bus_data", 32'(out_word.bus_data), 32'(want_word.bus_data));
				check_field("status", 32'(out_word.status), 32'(want_word.status));
				check_field("read_data", 32'(out_word.read_data), 32'(want_word.read_data));
				check_field("last", 32'(out_word.last), 32'(want_word.last));
			end
			words_seen++;
		end
	end

	// Receiver stalls: a mode is held for a random span of cycles.
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(20, 120);
		end
		stall_span--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ~out_ready;
			2:       out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Watchdog on cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** nor_flash_command_sequencer: FAILED **");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		drill_row_t  drills [DRILL_ROWS];
		logic [31:0] bases [4];
		result_word_t range_word;
		result_word_t abort_write;
		result_word_t abort_done;
		cmd_word_t   w;
		int          goal;
		int          pick;

		range_word  = bus_word(KIND_DONE, 32'h0, 8'h00, ST_RANGE, 8'h00, 1'b1);
		abort_write = bus_word(KIND_WRITE, 32'h0, FL_RESET, ST_OK, 8'h00, 1'b0);
		abort_done  = bus_word(KIND_DONE, 32'h0, 8'h00, ST_OK, 8'h00, 1'b1);
		drills = '{
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h5a}, 1'b1, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_RESET, 23'h000000, 8'h00, 7'd0,   8'h00}, 1'b1, 2'd2, abort_write, abort_done},
			'{'{CMD_READ,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'hff}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_READ,  23'h3fffff, 8'hff, 7'd127, 8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_READ,  23'h400000, 8'h00, 7'd0,   8'h00}, 1'b1, 2'd1, range_word, NO_WORD},
			'{'{CMD_PROG,  23'h7fffff, 8'h55, 7'd0,   8'h00}, 1'b1, 2'd1, range_word, NO_WORD},
			'{'{CMD_ERASE, 23'h000000, 8'h00, 7'd71,  8'h00}, 1'b1, 2'd1, range_word, NO_WORD},
			'{'{CMD_ERASE, 23'h000000, 8'h00, 7'd127, 8'h00}, 1'b1, 2'd1, range_word, NO_WORD},
			'{'{CMD_BAD_FIRST, 23'h000000, 8'h00, 7'd0, 8'h00}, 1'b1, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_PROG,  23'h000123, 8'hff, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h20}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_ERASE, 23'h000000, 8'h00, 7'd3,   8'h00}, 1'b1, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_PROG,  23'h002000, 8'h80, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_RESET, 23'h000000, 8'h00, 7'd0,   8'h00}, 1'b1, 2'd2, abort_write, abort_done},
			'{'{CMD_ERASE, 23'h000000, 8'h00, 7'd8,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h24}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h40}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_ERASE, 23'h000000, 8'h00, 7'd70,  8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD},
			'{'{CMD_POLL,  23'h000000, 8'h00, 7'd0,   8'h00}, 1'b0, 2'd0, NO_WORD, NO_WORD}
		};
		bases = '{32'h0000_0000, 32'hffff_ffff, $urandom,
			32'hffff_f000 | 32'($urandom_range(0, 4095))};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at base address zero.
		foreach (drills[k]) begin
			send_word(drills[k].word);
			sequence_bus_cycles(drills[k].word);
			if (drills[k].typed) begin
				if (drills[k].typed_count >= 1) begin
					bus_expect.push_back(drills[k].first_word);
				end
				if (drills[k].typed_count == 2) begin
					bus_expect.push_back(drills[k].second_word);
				end
			end else begin
				foreach (cycle_list[i]) begin
					bus_expect.push_back(cycle_list[i]);
				end
			end
		end

		// Random operations, one base address per phase.
		foreach (bases[p]) begin
			write_base(bases[p]);
			goal = result_items + 35;
			while (result_items < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 22) begin
					w = random_word(CMD_READ);
					w.offset[22] = ($urandom_range(0, 9) == 0);
					issue(w);
				end else if (pick < 50) begin
					w = random_word(CMD_PROG);
					w.offset[22] = ($urandom_range(0, 9) == 0);
					issue(w);
				end else if (pick < 78) begin
					w = random_word(CMD_ERASE);
					if ($urandom_range(0, 9) == 0) begin
						w.sector = 7'($urandom_range(SECTOR_COUNT, 127));
					end else begin
						w.sector = 7'($urandom_range(0, SECTOR_COUNT - 1));
					end
					issue(w);
				end else if (pick < 86) begin
					issue(random_word(CMD_RESET));
				end else if (pick < 94) begin
					// Words that an idle block ignores.
					if ($urandom_range(0, 1) == 0) begin
						issue(random_word(CMD_POLL));
					end else begin
						issue(random_word(3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST))));
					end
				end else begin
					drain();
				end

				// Poll replies until the operation ends, with some noise and aborts.
				while (seq_state != SQ_IDLE) begin
					pick = $urandom_range(0, 19);
					if (pick == 0) begin
						issue(random_word(CMD_RESET));
					end else if (pick == 1) begin
						issue(random_word(3'($urandom_range(CMD_READ, CMD_ERASE))));
					end else if (pick == 2) begin
						issue(random_word(3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST))));
					end else begin
						w = random_word(CMD_POLL);
						w.bus_read_value = poll_reply();
						issue(w);
					end
				end
			end
		end

		// Let the last words come out, then look for strays.
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		wait (bus_expect.size() == 0);
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("** nor_flash_command_sequencer: PASSED **");
		end else begin
			$display("** nor_flash_command_sequencer: FAILED **");
		end
		$finish;
	end

endmodule

FILE: nor_flash_command_sequencer.f
rtl/nfcs_pkg.sv
rtl/nfcs_ctrl.sv
rtl/nfcs_emit.sv
rtl/nor_flash_command_sequencer.sv
bench/nor_flash_command_sequencer_test.sv
